@@ hw/rtl/int_key_hash_table_quadratic_probe_assert.svh @@
// Assertion macros for the quadratic-probe hash table.
// Used by the top level only; the bodies are empty when SYNTH is defined.
`ifndef INT_KEY_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`define INT_KEY_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`ifndef SYNTH
`define IKHQP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ikhqp assertion failed");
`define IKHQP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ikhqp assertion failed");
`else
`define IKHQP_ASSERT_SAME(label, ante, cons)
`define IKHQP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/ikhqp_pkg.sv @@
// Shared types, codes and helpers for the quadratic-probe hash table.
// No dependencies; used by ikhqp_mod and the top level.
package ikhqp_pkg;

    localparam int SIZE_W = 11;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd1;
    localparam logic [2:0] ST_OVERLOAD  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_SLOT   = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd769;
    localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [VAL_W-1:0]  value_out;
        logic [SIZE_W-1:0] entry_count;
    } t_res;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] key_rem;
        logic [SIZE_W-1:0] p32_rem;
    } t_mod_res;

    // One restoring step: (2r + b) mod size, with r < size.
    function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] r,
                                                   input logic b,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] t;
        t = {r, b};
        if (t >= {1'b0, size}) begin
            t = t - {1'b0, size};
        end
        return t[SIZE_W-1:0];
    endfunction

    // (a + b) mod size, with a, b < size.
    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, size}) begin
            t = t - {1'b0, size};
        end
        return t[SIZE_W-1:0];
    endfunction

endpackage

@@ hw/rtl/ikhqp_mod.sv @@
// Iterative remainder unit: key mod size and 2^32 mod size, four bits a cycle.
// Depends on ikhqp_pkg.
module ikhqp_mod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ikhqp_pkg::KEY_W-1:0]     i_key,
    input  logic [ikhqp_pkg::SIZE_W-1:0]    i_size,
    output ikhqp_pkg::t_mod_res             o_res
);
    localparam int STEPS = 4;

    logic                         r_busy;
    logic                         r_done;
    logic [2:0]                   r_cnt;
    logic [ikhqp_pkg::KEY_W-1:0]  r_key;
    logic [ikhqp_pkg::SIZE_W-1:0] r_size;
    logic [ikhqp_pkg::SIZE_W-1:0] r_krem;
    logic [ikhqp_pkg::SIZE_W-1:0] r_prem;
    logic [ikhqp_pkg::SIZE_W-1:0] n_krem;
    logic [ikhqp_pkg::SIZE_W-1:0] n_prem;

    always_comb begin
        n_krem = r_krem;
        n_prem = r_prem;
        for (int i = 0; i < STEPS; i++) begin
            n_krem = ikhqp_pkg::mod_step(n_krem, r_key[ikhqp_pkg::KEY_W-1-i], r_size);
            n_prem = ikhqp_pkg::mod_step(n_prem, 1'b0, r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_size <= i_size;
            r_krem <= '0;
            // 2^32 starts from a leading one; size is at least two
            r_prem <= ikhqp_pkg::SIZE_W'(1);
        end else if (r_busy) begin
            r_key  <= r_key << STEPS;
            r_krem <= n_krem;
            r_prem <= n_prem;
        end
    end

    assign o_res.done    = r_done;
    assign o_res.key_rem = r_krem;
    assign o_res.p32_rem = r_prem;

endmodule

@@ hw/rtl/int_key_hash_table_quadratic_probe.sv @@
// Quadratic-probe hash table, one request at a time.
// Steps: accept, remainder, then an address state and a check state per probe, result;
// zero-key, overload and unknown requests go from accept straight to the result. No new
// request is taken before the last is out, as the probe walk holds the single slot memory.
// Reset: synchronous; afterwards a clearing pass over all CAPACITY rows wipes the slot
// flags while no request is taken. Configuration writes are taken at any time.
`include "int_key_hash_table_quadratic_probe_assert.svh"
module int_key_hash_table_quadratic_probe #(
    parameter int CAPACITY = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ikhqp_pkg::t_req        i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ikhqp_pkg::t_res        o_out_word,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int SW    = ikhqp_pkg::SIZE_W;
    localparam int ROW_W = 2 + ikhqp_pkg::KEY_W + ikhqp_pkg::VAL_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Row: live, tombstone, key, value
    logic [ROW_W-1:0] mem [CAPACITY];
    logic [ROW_W-1:0] r_rdata;

    logic [2:0]           r_state;
    logic [AW-1:0]        r_clr;
    logic [SW-1:0]        r_table_size;
    logic [SW-1:0]        r_size;
    logic [SW-1:0]        eff_size;
    logic [SW-1:0]        r_live_count;
    ikhqp_pkg::t_req      r_req;
    ikhqp_pkg::t_res      r_res;
    ikhqp_pkg::t_res      r_out;
    logic                 r_out_valid;
    logic [SW-1:0]        r_k;
    logic [2*SW-1:0]      r_sq;
    logic [SW-1:0]        r_sqm;
    logic [SW-1:0]        r_om;
    logic [SW-1:0]        r_km;
    logic [SW-1:0]        r_p32;
    logic [AW-1:0]        r_slot;
    logic [AW-1:0]        slot_addr;
    logic [SW-1:0]        slot_val;
    logic [ikhqp_pkg::KEY_W:0] sum33;
    logic [SW-1:0]        t_base;
    logic                 mod_start;
    ikhqp_pkg::t_mod_res  mod_res;
    logic                 in_acc;
    logic                 cfg_wr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic                 rd_live;
    logic                 rd_tomb;
    logic [ikhqp_pkg::KEY_W-1:0] rd_key;
    logic [ikhqp_pkg::VAL_W-1:0] rd_val;
    logic                 last_probe;
    logic                 out_load;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = {{(32-SW){1'b0}}, r_table_size};
    assign mod_start = in_acc;

    always_comb begin
        if (32'(r_table_size) > CAPACITY) begin
            eff_size = SW'(CAPACITY);
        end else if (r_table_size < SW'(2)) begin
            eff_size = SW'(2);
        end else begin
            eff_size = r_table_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= ikhqp_pkg::SIZE_RESET;
        end else if (cfg_wr && paddr == ikhqp_pkg::ADDR_TABLE_SIZE) begin
            r_table_size <= pwdata[SW-1:0];
        end
    end

    ikhqp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_in_word.key),
        .i_size  (eff_size),
        .o_res   (mod_res)
    );

    // Probe slot: (key mod size + k^2 mod size - carry * (2^32 mod size)) mod size
    always_comb begin
        sum33    = {1'b0, r_req.key} + (ikhqp_pkg::KEY_W + 1)'(r_sq);
        t_base   = ikhqp_pkg::mod_add(r_km, r_sqm, r_size);
        slot_val = t_base;
        if (sum33[ikhqp_pkg::KEY_W]) begin
            if (t_base >= r_p32) begin
                slot_val = t_base - r_p32;
            end else begin
                slot_val = SW'({1'b0, t_base} + {1'b0, r_size} - {1'b0, r_p32});
            end
        end
        slot_addr = AW'(slot_val);
    end

    assign rd_live    = r_rdata[ROW_W-1];
    assign rd_tomb    = r_rdata[ROW_W-2];
    assign rd_key     = r_rdata[ikhqp_pkg::KEY_W+ikhqp_pkg::VAL_W-1:ikhqp_pkg::VAL_W];
    assign rd_val     = r_rdata[ikhqp_pkg::VAL_W-1:0];
    assign last_probe = ({1'b0, r_k} + (SW+1)'(1)) == {1'b0, r_size};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {2'b00, rd_key, rd_val};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_CHECK: begin
                if (r_req.req_type == ikhqp_pkg::REQ_INSERT) begin
                    if (!rd_live) begin
                        mem_we    = 1'b1;
                        mem_wdata = {2'b10, r_req.key, r_req.value};
                    end
                end else if (rd_live && rd_key == r_req.key
                             && r_req.req_type == ikhqp_pkg::REQ_REMOVE) begin
                    // leave a tombstone so later chains stay reachable
                    mem_we    = 1'b1;
                    mem_wdata = {2'b01, rd_key, rd_val};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_live_count <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (i_in_word.req_type == ikhqp_pkg::REQ_INSERT) begin
                            if (i_in_word.key == '0) begin
                                r_state <= S_DONE;
                            end else if ((16'(r_live_count) * 16'd20)
                                         > (16'(eff_size) * 16'd13)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_MOD;
                            end
                        end else if ((i_in_word.req_type == ikhqp_pkg::REQ_LOOKUP
                                      || i_in_word.req_type == ikhqp_pkg::REQ_REMOVE)
                                     && i_in_word.key != '0) begin
                            r_state <= S_MOD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_res.done) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= S_ADDR;
                    if (r_req.req_type == ikhqp_pkg::REQ_INSERT) begin
                        if (!rd_live) begin
                            r_live_count <= r_live_count + SW'(1);
                            r_state      <= S_DONE;
                        end else if (last_probe) begin
                            r_state <= S_DONE;
                        end
                    end else if (rd_live && rd_key == r_req.key) begin
                        if (r_req.req_type == ikhqp_pkg::REQ_REMOVE) begin
                            r_live_count <= r_live_count - SW'(1);
                        end
                        r_state <= S_DONE;
                    end else if ((!rd_live && !rd_tomb) || last_probe) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers for the request in flight
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req <= i_in_word;
                r_size <= eff_size;
                r_res.value_out   <= '0;
                r_res.entry_count <= r_live_count;
                priority if (i_in_word.req_type == ikhqp_pkg::REQ_INSERT
                             && i_in_word.key == '0) begin
                    r_res.status <= ikhqp_pkg::ST_ZERO_KEY;
                end else if (i_in_word.req_type == ikhqp_pkg::REQ_INSERT) begin
                    r_res.status <= ikhqp_pkg::ST_OVERLOAD;
                end else begin
                    r_res.status <= ikhqp_pkg::ST_NOT_FOUND;
                end
            end
            S_MOD: begin
                r_k   <= '0;
                r_sq  <= '0;
                r_sqm <= '0;
                r_om  <= SW'(1);
                r_km  <= mod_res.key_rem;
                r_p32 <= mod_res.p32_rem;
            end
            S_ADDR: begin
                r_slot <= slot_addr;
            end
            S_CHECK: begin
                // advance to the next probe: k^2 grows by 2k+1
                r_k   <= r_k + SW'(1);
                r_sq  <= r_sq + (2*SW)'({r_k, 1'b1});
                r_sqm <= ikhqp_pkg::mod_add(r_sqm, r_om, r_size);
                r_om  <= ikhqp_pkg::mod_add(r_om, SW'(2), r_size);
                if (r_req.req_type == ikhqp_pkg::REQ_INSERT) begin
                    if (!rd_live) begin
                        r_res.status      <= ikhqp_pkg::ST_OK;
                        r_res.entry_count <= r_live_count + SW'(1);
                    end else begin
                        r_res.status <= ikhqp_pkg::ST_NO_SLOT;
                    end
                end else if (rd_live && rd_key == r_req.key) begin
                    r_res.status    <= ikhqp_pkg::ST_OK;
                    r_res.value_out <= rd_val;
                    if (r_req.req_type == ikhqp_pkg::REQ_REMOVE) begin
                        r_res.entry_count <= r_live_count - SW'(1);
                    end
                end else begin
                    r_res.status <= ikhqp_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `IKHQP_ASSERT_SAME(a_check_after_addr, r_state == S_CHECK, $past(r_state) == S_ADDR)
    `IKHQP_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall, r_state != S_IDLE)
    `IKHQP_ASSERT_SAME(a_slot_in_range, r_state == S_CHECK, {1'b0, r_slot} < (AW+1)'(r_size))

endmodule

@@ verif/int_key_hash_table_quadratic_probe_tb.sv @@
// Testbench for the quadratic-probe hash table: random and directed requests,
// APB size writes, and a scoreboard that models the table. Depends on ikhqp_pkg.
module int_key_hash_table_quadratic_probe_tb;

    localparam int CAP = 1024;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam logic [1:0] REQ_BAD = 2'd3;

    class hash_table_scoreboard;
        logic [31:0] key_mem[CAP];
        logic [31:0] val_mem[CAP];
        bit live[CAP];
        bit tomb[CAP];
        int unsigned live_cnt;
        logic [10:0] size_reg;
        ikhqp_pkg::t_res pending[$];
        int errors;

        function void clear();
            foreach (live[i]) begin
                live[i] = 0;
                tomb[i] = 0;
            end
            live_cnt = 0;
            size_reg = ikhqp_pkg::SIZE_RESET;
            errors = 0;
        endfunction

        function int unsigned active_size();
            int unsigned s;
            s = size_reg;
            if (s < 2) s = 2;
            if (s > CAP) s = CAP;
            return s;
        endfunction

        function int unsigned slot_of(logic [31:0] key, int unsigned k, int unsigned s);
            logic [31:0] sum;
            sum = key + k * k;
            return sum % s;
        endfunction

        function int find_live(logic [31:0] key);
            int unsigned s, p;
            s = active_size();
            for (int unsigned k = 0; k < s; k++) begin
                p = slot_of(key, k, s);
                if (!live[p] && !tomb[p]) return -1;
                if (live[p] && key_mem[p] == key) return p;
            end
            return -1;
        endfunction

        // Note an accepted request: apply it and queue the expected word.
        function void note_request(ikhqp_pkg::t_req rq);
            ikhqp_pkg::t_res r;
            int unsigned s, p;
            int f;
            r.status = ikhqp_pkg::ST_NOT_FOUND;
            r.value_out = '0;
            s = active_size();
            if (rq.req_type == ikhqp_pkg::REQ_INSERT) begin
                if (rq.key == 0) r.status = ikhqp_pkg::ST_ZERO_KEY;
                else if (live_cnt * 20 > s * 13) r.status = ikhqp_pkg::ST_OVERLOAD;
                else begin
                    r.status = ikhqp_pkg::ST_NO_SLOT;
                    for (int unsigned k = 0; k < s; k++) begin
                        p = slot_of(rq.key, k, s);
                        if (!live[p]) begin
                            key_mem[p] = rq.key;
                            val_mem[p] = rq.value;
                            live[p] = 1;
                            tomb[p] = 0;
                            live_cnt++;
                            r.status = ikhqp_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end else if (rq.req_type == ikhqp_pkg::REQ_LOOKUP
                         || rq.req_type == ikhqp_pkg::REQ_REMOVE) begin
                f = find_live(rq.key);
                if (f >= 0) begin
                    r.value_out = val_mem[f];
                    r.status = ikhqp_pkg::ST_OK;
                    if (rq.req_type == ikhqp_pkg::REQ_REMOVE) begin
                        live[f] = 0;
                        tomb[f] = 1;
                        live_cnt--;
                    end
                end
            end
            r.entry_count = live_cnt[10:0];
            pending.push_back(r);
        endfunction

        function void check_result(ikhqp_pkg::t_res got);
            ikhqp_pkg::t_res exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status || got.value_out !== exp_r.value_out ||
                got.entry_count !== exp_r.entry_count) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected st=%0d val=%h cnt=%0d, ",
                              "got st=%0d val=%h cnt=%0d"},
                             exp_r.status, exp_r.value_out, exp_r.entry_count,
                             got.status, got.value_out, got.entry_count);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    ikhqp_pkg::t_req i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    ikhqp_pkg::t_res o_out_word;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hash_table_scoreboard table_sb;
    longint cycle_cnt = 0;
    bit hold_off = 0;
    bit drain_idle = 0;
    logic [31:0] key_pool[16];

    int_key_hash_table_quadratic_probe DUT (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) table_sb.check_result(o_out_word);
    end

    // Receiver: random stall per word, plus a long hold-off when asked.
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_out_stall <= 1;
            else if (drain_idle) i_out_stall <= 0;
            else begin
                w = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w != 0) begin
                    i_out_stall <= 1;
                    repeat (w) @(negedge i_clk);
                end
                i_out_stall <= 0;
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
            end
        end
    end

    // Hold valid past the accepting edge until the next falling edge; the block
    // stalls right after an accept, so the old word is never taken twice.
    task automatic send_req(logic [1:0] rt, logic [31:0] k, logic [31:0] v, bit gaps);
        int w;
        ikhqp_pkg::t_req rq;
        w = gaps ? $urandom_range(0, 15) : 0;
        rq.req_type = rt;
        rq.key = k;
        rq.value = v;
        @(negedge i_clk);
        if (w != 0) begin
            i_in_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_in_word <= rq;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        table_sb.note_request(rq);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 0;
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_size(logic [10:0] s);
        psel <= 1;
        pwrite <= 1;
        paddr <= ikhqp_pkg::ADDR_TABLE_SIZE;
        pwdata <= {21'd0, s};
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        table_sb.size_reg = s;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic random_phase(int n, int unsigned key_span);
        logic [1:0] rt;
        logic [31:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            rt = (r < 45) ? ikhqp_pkg::REQ_INSERT : (r < 75) ? ikhqp_pkg::REQ_LOOKUP :
                 (r < 97) ? ikhqp_pkg::REQ_REMOVE : REQ_BAD;
            if ($urandom_range(0, 9) == 0) k = $urandom();
            else if ($urandom_range(0, 3) == 0) k = key_pool[$urandom_range(0, 15)];
            else k = $urandom_range(0, key_span);
            send_req(rt, k, $urandom(), 1);
        end
    endtask

    initial begin
        int sz;
        table_sb = new();
        table_sb.clear();
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every request kind, zero key, unknown code.
        send_req(ikhqp_pkg::REQ_INSERT, 32'h0, 32'h1234, 0);
        send_req(ikhqp_pkg::REQ_LOOKUP, 32'h0, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_req(ikhqp_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_INSERT, 32'd769, 32'hA5A5_5A5A, 0);
        send_req(ikhqp_pkg::REQ_INSERT, 32'd1538, 32'h5A5A_A5A5, 0);
        send_req(ikhqp_pkg::REQ_REMOVE, 32'd769, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_LOOKUP, 32'd1538, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_INSERT, 32'd2307, 32'h1, 0);
        send_req(REQ_BAD, 32'd1538, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_REMOVE, 32'd12345, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 0);
        send_req(ikhqp_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0);

        // Back-pressure: hold the receiver while requests keep coming.
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(30, 3000);
        join
        random_phase(100, 3000);
        wait_idle();

        // Size sweep from the smallest size: fills, overload, no free slot, tombstone reuse.
        write_size(11'd2);
        random_phase(40, 8);
        wait_idle();
        write_size(11'd0);
        random_phase(20, 8);
        wait_idle();
        write_size(11'd3);
        random_phase(40, 12);
        wait_idle();
        write_size(11'd7);
        random_phase(60, 40);
        wait_idle();
        write_size(11'd1024);
        random_phase(80, 5000);
        wait_idle();
        write_size(11'h7FF);
        random_phase(40, 5000);
        wait_idle();
        sz = $urandom_range(0, 1) ? 53 : 13;
        write_size(sz[10:0]);
        random_phase(120, 200);
        wait_idle();
        write_size(ikhqp_pkg::SIZE_RESET);
        random_phase(60, 100000);

        drain_idle = 1;
        wait_idle();
        if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ int_key_hash_table_quadratic_probe.f @@
+incdir+hw/rtl
hw/rtl/ikhqp_pkg.sv
hw/rtl/ikhqp_mod.sv
hw/rtl/int_key_hash_table_quadratic_probe.sv
verif/int_key_hash_table_quadratic_probe_tb.sv
